@@ rtl/ieu_pkg.sv @@
// Shared constants, codes and helpers of the infix expression evaluator.
package ieu_pkg;

  localparam int unsigned StackDepthDef   = 32;
  localparam int unsigned FractionBitsDef = 32;

  localparam logic [63:0] SignMin = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PosMax  = 64'h7FFF_FFFF_FFFF_FFFF;

  // token kinds on the input word
  localparam logic [2:0] TK_NUMBER = 3'd0;
  localparam logic [2:0] TK_OPER   = 3'd1;
  localparam logic [2:0] TK_OPEN   = 3'd2;
  localparam logic [2:0] TK_CLOSE  = 3'd3;
  localparam logic [2:0] TK_END    = 3'd4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SYNTAX   = 2'd1,
    ST_DIVZERO  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // operator stack entry codes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_PAREN = 3'd4;

  function automatic logic [1:0] op_prio(logic [2:0] op);
    logic [1:0] p;
    if (op == OP_PAREN) p = 2'd0;
    else if (op >= OP_MUL) p = 2'd2;
    else p = 2'd1;
    return p;
  endfunction

endpackage

@@ rtl/ieu_alu.sv @@
// Multi-cycle saturating fixed-point arithmetic unit: add, subtract, multiply, divide.
module ieu_alu #(
  parameter int unsigned FRACTION_BITS = ieu_pkg::FractionBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  op_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] result_o
);
  import ieu_pkg::*;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_SAT  = 4'b1000
  } alu_state_e;

  alu_state_e   state_q, state_d;
  logic         done_q, done_d;
  logic         is_mul_q, is_mul_d;
  logic         neg_q, neg_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [63:0]  ma_q, ma_d, mb_q, mb_d;
  logic [63:0]  pp_q, pp_d;
  logic [127:0] acc_q, acc_d;
  logic [127:0] num_q, num_d;
  logic [63:0]  rem_q, rem_d;
  logic [63:0]  res_q, res_d;

  logic [63:0]  mag_a, mag_b, sum, dif;
  logic [31:0]  half_a, half_b;
  logic [1:0]   prev;
  logic [127:0] pp_shift;
  logic [64:0]  trial, trial_sub;
  logic         ge;
  logic [127:0] src;

  assign mag_a = a_i[63] ? (64'd0 - a_i) : a_i;
  assign mag_b = b_i[63] ? (64'd0 - b_i) : b_i;
  assign sum   = a_i + b_i;
  assign dif   = a_i - b_i;

  assign half_a = cnt_q[0] ? ma_q[63:32] : ma_q[31:0];
  assign half_b = cnt_q[1] ? mb_q[63:32] : mb_q[31:0];
  assign prev   = cnt_q[1:0] - 2'd1;

  always_comb begin
    case ({1'b0, prev[0]} + {1'b0, prev[1]})
      2'd0:    pp_shift = {64'd0, pp_q};
      2'd1:    pp_shift = {32'd0, pp_q, 32'd0};
      default: pp_shift = {pp_q, 64'd0};
    endcase
  end

  assign trial     = {rem_q, num_q[127]};
  assign ge        = trial >= {1'b0, mb_q};
  assign trial_sub = trial - {1'b0, mb_q};
  assign src       = is_mul_q ? (acc_q >> FRACTION_BITS) : acc_q;

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    is_mul_d = is_mul_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    ma_d     = ma_q;
    mb_d     = mb_q;
    pp_d     = pp_q;
    acc_d    = acc_q;
    num_d    = num_q;
    rem_d    = rem_q;
    res_d    = res_q;
    case (state_q)
      A_IDLE: begin
        if (start_i) begin
          neg_d = a_i[63] ^ b_i[63];
          cnt_d = 7'd0;
          acc_d = '0;
          ma_d  = mag_a;
          mb_d  = mag_b;
          rem_d = '0;
          num_d = {64'd0, mag_a} << FRACTION_BITS;
          case (op_i)
            OP_ADD: begin
              res_d  = sum;
              if (a_i[63] == b_i[63] && sum[63] != a_i[63])
                res_d = a_i[63] ? SignMin : PosMax;
              done_d = 1'b1;
            end
            OP_SUB: begin
              res_d  = dif;
              if (a_i[63] != b_i[63] && dif[63] != a_i[63])
                res_d = a_i[63] ? SignMin : PosMax;
              done_d = 1'b1;
            end
            OP_MUL: begin
              is_mul_d = 1'b1;
              state_d  = A_MUL;
            end
            default: begin
              is_mul_d = 1'b0;
              state_d  = A_DIV;
            end
          endcase
        end
      end
      A_MUL: begin
        // partial product of this step, accumulate the previous one
        pp_d  = {32'd0, half_a} * {32'd0, half_b};
        if (cnt_q != 7'd0) acc_d = acc_q + pp_shift;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd4) state_d = A_SAT;
      end
      A_DIV: begin
        rem_d = ge ? trial_sub[63:0] : trial[63:0];
        acc_d = {acc_q[126:0], ge};
        num_d = {num_q[126:0], 1'b0};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd127) state_d = A_SAT;
      end
      A_SAT: begin
        if (neg_q) begin
          if (src[127:64] != 64'd0 || src[63:0] > SignMin) res_d = SignMin;
          else res_d = 64'd0 - src[63:0];
        end else begin
          if (src[127:64] != 64'd0 || src[63:0] > PosMax) res_d = PosMax;
          else res_d = src[63:0];
        end
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_mul_q <= is_mul_d;
    neg_q    <= neg_d;
    cnt_q    <= cnt_d;
    ma_q     <= ma_d;
    mb_q     <= mb_d;
    pp_q     <= pp_d;
    acc_q    <= acc_d;
    num_q    <= num_d;
    rem_q    <= rem_d;
    res_q    <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

@@ rtl/infix_expression_evaluator_unit.sv @@
// Top level of the infix expression evaluator: token control, stack memories, output register.
//
// Input channel: one token word per handshake (in_valid_i high, in_stall_o low).
// Numbers and open parentheses are handled in S_IDLE. Operators, close
// parentheses and the end token walk the operator stack: each operator they
// reduce costs a read of the top (S_RD_TOP, S_CHK), an operand read (S_RD_A)
// and the arithmetic unit (S_ALU; add and subtract finish sooner than multiply
// and divide), and in_stall_o stays high while the stack is walked.
// Stacks live in two synchronous memories of STACK_DEPTH entries, one read and
// one write port each; the arithmetic unit is shared by all reductions.
// Output channel: only the end token produces a word (value and status); it
// is held in an output register until out_stall_i is low. If the previous
// word is still stalled, the end token waits in its last step.
// Reset empties both stacks through their counts, clears the status to
// success and expects an operand; no clearing pass is needed.
module infix_expression_evaluator_unit #(
  parameter int unsigned STACK_DEPTH   = ieu_pkg::StackDepthDef,
  parameter int unsigned FRACTION_BITS = ieu_pkg::FractionBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         token_kind_i,
  input  logic [1:0]         operator_code_i,
  input  logic signed [63:0] number_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] result_value_o,
  output logic [1:0]         result_status_o
);
  import ieu_pkg::*;

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_RD_TOP  = 7'b0000010,
    S_CHK     = 7'b0000100,
    S_RD_A    = 7'b0001000,
    S_ALU     = 7'b0010000,
    S_FIN     = 7'b0100000,
    S_END_OUT = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  logic [CntW-1:0] opnd_cnt_q, opnd_cnt_d, oper_cnt_q, oper_cnt_d;
  logic        expect_q, expect_d;
  status_e     status_q, status_d;
  logic [2:0]  kind_q, kind_d;
  logic [1:0]  opc_q, opc_d;
  logic [2:0]  op_q, op_d;
  logic [63:0] b_q, b_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_value_q, out_value_d;
  status_e     out_status_q, out_status_d;

  logic [63:0] opnd_mem [STACK_DEPTH];
  logic [2:0]  oper_mem [STACK_DEPTH];
  logic [63:0] opnd_rdata_q;
  logic [2:0]  oper_rdata_q;
  logic [AddrW-1:0] opnd_raddr, oper_raddr, opnd_waddr, oper_waddr;
  logic        opnd_we, oper_we;
  logic [63:0] opnd_wdata;
  logic [2:0]  oper_wdata;

  logic [CntW-1:0] opnd_m1, opnd_m2, oper_m1;
  logic        in_acc, out_free, do_red;
  logic        alu_start, alu_done;
  logic [63:0] alu_res;

  assign opnd_m1  = opnd_cnt_q - CntW'(1);
  assign opnd_m2  = opnd_cnt_q - CntW'(2);
  assign oper_m1  = oper_cnt_q - CntW'(1);
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  ieu_alu #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .op_i    (op_q),
    .a_i     (opnd_rdata_q),
    .b_i     (b_q),
    .done_o  (alu_done),
    .result_o(alu_res)
  );

  always_comb begin
    state_d      = state_q;
    opnd_cnt_d   = opnd_cnt_q;
    oper_cnt_d   = oper_cnt_q;
    expect_d     = expect_q;
    status_d     = status_q;
    kind_d       = kind_q;
    opc_d        = opc_q;
    op_d         = op_q;
    b_d          = b_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    opnd_raddr   = opnd_m1[AddrW-1:0];
    oper_raddr   = oper_m1[AddrW-1:0];
    opnd_we      = 1'b0;
    opnd_waddr   = opnd_cnt_q[AddrW-1:0];
    opnd_wdata   = number_value_i;
    oper_we      = 1'b0;
    oper_waddr   = oper_cnt_q[AddrW-1:0];
    oper_wdata   = OP_PAREN;
    alu_start    = 1'b0;
    do_red       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          kind_d = token_kind_i;
          opc_d  = operator_code_i;
          if (token_kind_i == TK_END) begin
            if (status_q == ST_OK && !expect_q) status_d = ST_SYNTAX;
            state_d = S_RD_TOP;
          end else if (status_q == ST_OK) begin
            case (token_kind_i)
              TK_NUMBER: begin
                if (expect_q) status_d = ST_SYNTAX;
                else if (opnd_cnt_q == CntW'(STACK_DEPTH)) status_d = ST_OVERFLOW;
                else begin
                  opnd_we    = 1'b1;
                  opnd_cnt_d = opnd_cnt_q + CntW'(1);
                  expect_d   = 1'b1;
                end
              end
              TK_OPER, TK_CLOSE: begin
                if (!expect_q) status_d = ST_SYNTAX;
                else state_d = S_RD_TOP;
              end
              TK_OPEN: begin
                if (expect_q) status_d = ST_SYNTAX;
                else if (oper_cnt_q == CntW'(STACK_DEPTH)) status_d = ST_OVERFLOW;
                else begin
                  oper_we    = 1'b1;
                  oper_cnt_d = oper_cnt_q + CntW'(1);
                end
              end
              default: status_d = ST_SYNTAX;
            endcase
          end
        end
      end
      S_RD_TOP: begin
        // read top operator and top operand together
        if (status_q != ST_OK || oper_cnt_q == '0) state_d = S_FIN;
        else state_d = S_CHK;
      end
      S_CHK: begin
        state_d = S_FIN;
        case (kind_q)
          TK_END: begin
            if (oper_rdata_q == OP_PAREN) begin
              status_d = ST_SYNTAX;
              state_d  = S_RD_TOP;
            end else do_red = 1'b1;
          end
          TK_OPER: do_red = op_prio(oper_rdata_q) >= op_prio({1'b0, opc_q});
          default: do_red = oper_rdata_q != OP_PAREN;
        endcase
        if (do_red) begin
          if (opnd_cnt_q < CntW'(2)) begin
            status_d = ST_SYNTAX;
            state_d  = S_RD_TOP;
          end else begin
            b_d        = opnd_rdata_q;
            op_d       = oper_rdata_q;
            opnd_raddr = opnd_m2[AddrW-1:0];
            state_d    = S_RD_A;
          end
        end
      end
      S_RD_A: begin
        if (op_q == OP_DIV && b_q == 64'd0) begin
          status_d   = ST_DIVZERO;
          oper_cnt_d = oper_m1;
          state_d    = S_RD_TOP;
        end else begin
          alu_start = 1'b1;
          state_d   = S_ALU;
        end
      end
      S_ALU: begin
        if (alu_done) begin
          opnd_we    = 1'b1;
          opnd_waddr = opnd_m2[AddrW-1:0];
          opnd_wdata = alu_res;
          opnd_cnt_d = opnd_m1;
          oper_cnt_d = oper_m1;
          state_d    = S_RD_TOP;
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
        case (kind_q)
          TK_END: state_d = S_END_OUT;
          TK_OPER: begin
            if (status_q == ST_OK) begin
              if (oper_cnt_q == CntW'(STACK_DEPTH)) status_d = ST_OVERFLOW;
              else begin
                oper_we    = 1'b1;
                oper_wdata = {1'b0, opc_q};
                oper_cnt_d = oper_cnt_q + CntW'(1);
                expect_d   = 1'b0;
              end
            end
          end
          default: begin
            if (status_q == ST_OK) begin
              if (oper_cnt_q == '0) status_d = ST_SYNTAX;
              else oper_cnt_d = oper_m1;
            end
          end
        endcase
      end
      S_END_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_value_d  = (status_q == ST_OK && opnd_cnt_q != '0) ? opnd_rdata_q : 64'd0;
          opnd_cnt_d   = '0;
          oper_cnt_d   = '0;
          expect_d     = 1'b0;
          status_d     = ST_OK;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      opnd_cnt_q  <= '0;
      oper_cnt_q  <= '0;
      expect_q    <= 1'b0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      opnd_cnt_q  <= opnd_cnt_d;
      oper_cnt_q  <= oper_cnt_d;
      expect_q    <= expect_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    opc_q        <= opc_d;
    op_q         <= op_d;
    b_q          <= b_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (opnd_we) opnd_mem[opnd_waddr] <= opnd_wdata;
    if (oper_we) oper_mem[oper_waddr] <= oper_wdata;
    opnd_rdata_q <= opnd_mem[opnd_raddr];
    oper_rdata_q <= oper_mem[oper_raddr];
  end

  assign in_stall_o      = state_q != S_IDLE;
  assign out_valid_o     = out_valid_q;
  assign result_value_o  = out_value_q;
  assign result_status_o = out_status_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    opnd_cnt_q <= CntW'(STACK_DEPTH) && oper_cnt_q <= CntW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_alu_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_start |-> opnd_cnt_q >= CntW'(2) && oper_cnt_q != '0 && status_q == ST_OK)
    else $error("reduction started without operands or after an error");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_END_OUT && out_free) |=>
      out_valid_q && opnd_cnt_q == '0 && oper_cnt_q == '0 && status_q == ST_OK)
    else $error("end token did not deliver and clear");

  a_alu_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> state_q == S_ALU)
    else $error("arithmetic result outside reduction");

endmodule
